/* hw/rtl/wfafc_pkg.sv */
package wfafc_pkg;

    localparam int STATION_ENTRIES = 8;
    localparam int STA_AW  = (STATION_ENTRIES > 1) ? $clog2(STATION_ENTRIES) : 1;
    localparam int STA_CW  = $clog2(STATION_ENTRIES + 1);
    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 32;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int REG_LSB   = 3;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_BSSID  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STATION_COUNT = 2'd2;

    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] FM_ALL     = 2'd0;
    localparam logic [1:0] FM_BSSID   = 2'd1;
    localparam logic [1:0] FM_STATION = 2'd2;

    localparam logic [1:0] KIND_MGMT = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;

    localparam int FC_TO_DS_BIT   = 8;
    localparam int FC_FROM_DS_BIT = 9;

    localparam logic [11:0] MIN_FRAME_LEN   = 12'd10;
    localparam logic [11:0] FULL_HEADER_LEN = 12'd24;

    typedef struct packed {
        logic [1:0]        filter_mode;
        logic [ADDR_W-1:0] filter_bssid;
        logic [3:0]        station_count;
    } t_cfg;

endpackage

/* hw/rtl/wfafc_in_if.sv */
interface wfafc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] frame_length;
    logic [1:0]  frame_kind;
    logic [15:0] frame_control;
    logic [47:0] address_one;
    logic [47:0] address_two;
    logic [47:0] address_three;
    logic [2:0]  entry_index;
    logic [47:0] entry_address;

    modport source (
        output valid, mode, frame_length, frame_kind, frame_control,
               address_one, address_two, address_three, entry_index, entry_address,
        input  ready
    );
    modport sink (
        input  valid, mode, frame_length, frame_kind, frame_control,
               address_one, address_two, address_three, entry_index, entry_address,
        output ready
    );
endinterface

/* hw/rtl/wfafc_out_if.sv */
interface wfafc_out_if;
    logic        valid;
    logic        ready;
    logic        counted;
    logic [31:0] frame_count;

    modport source (output valid, counted, frame_count, input ready);
    modport sink (input valid, counted, frame_count, output ready);
endinterface

/* hw/rtl/wfafc_ram.sv */
module wfafc_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 48
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/wfafc_cfg.sv */
module wfafc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfafc_pkg::PADDR_W-1:0] paddr,
    input  logic [wfafc_pkg::PDATA_W-1:0] pwdata,
    output logic [wfafc_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output wfafc_pkg::t_cfg               o_cfg
);

    wfafc_pkg::t_cfg                     r_cfg;
    logic [wfafc_pkg::REG_IDX_W-1:0]     w_idx;

    assign w_idx  = paddr[wfafc_pkg::PADDR_W-1:wfafc_pkg::REG_LSB];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                wfafc_pkg::REG_FILTER_MODE: begin
                    r_cfg.filter_mode <= pwdata[1:0];
                end
                wfafc_pkg::REG_FILTER_BSSID: begin
                    r_cfg.filter_bssid <= pwdata[wfafc_pkg::ADDR_W-1:0];
                end
                wfafc_pkg::REG_STATION_COUNT: begin
                    r_cfg.station_count <= pwdata[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            wfafc_pkg::REG_FILTER_MODE: begin
                prdata = {{(wfafc_pkg::PDATA_W-2){1'b0}}, r_cfg.filter_mode};
            end
            wfafc_pkg::REG_FILTER_BSSID: begin
                prdata = {{(wfafc_pkg::PDATA_W-wfafc_pkg::ADDR_W){1'b0}}, r_cfg.filter_bssid};
            end
            wfafc_pkg::REG_STATION_COUNT: begin
                prdata = {{(wfafc_pkg::PDATA_W-4){1'b0}}, r_cfg.station_count};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/wfafc_ctrl.sv */
module wfafc_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wfafc_pkg::t_cfg                      i_cfg,
    wfafc_in_if.sink                             i_item,
    wfafc_out_if.source                          o_result,
    output logic                                 o_wr_en,
    output logic [wfafc_pkg::STA_AW-1:0]         o_wr_addr,
    output logic [wfafc_pkg::ADDR_W-1:0]         o_wr_data,
    output logic                                 o_rd_en,
    output logic [wfafc_pkg::STA_AW-1:0]         o_rd_addr,
    input  logic [wfafc_pkg::ADDR_W-1:0]         i_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                      r_mode, n_mode;
    logic [11:0]                     r_len, n_len;
    logic [1:0]                      r_kind, n_kind;
    logic [15:0]                     r_fc, n_fc;
    logic [wfafc_pkg::ADDR_W-1:0]    r_a1, n_a1;
    logic [wfafc_pkg::ADDR_W-1:0]    r_a2, n_a2;
    logic [wfafc_pkg::ADDR_W-1:0]    r_a3, n_a3;
    logic [2:0]                      r_eidx, n_eidx;
    logic [wfafc_pkg::ADDR_W-1:0]    r_eaddr, n_eaddr;

    logic [wfafc_pkg::STA_CW-1:0]    r_idx, n_idx;
    logic                            r_issue, n_issue;
    logic                            r_pend, n_pend;
    logic                            r_last, n_last;
    logic                            r_hit, n_hit;
    logic                            r_verdict, n_verdict;

    logic                            r_ovalid, n_ovalid;
    logic                            r_ocounted, n_ocounted;
    logic [wfafc_pkg::COUNT_W-1:0]   r_ocount, n_ocount;
    logic [wfafc_pkg::COUNT_W-1:0]   r_count, n_count;

    logic                            w_load;
    logic                            w_base, w_hdr_ok, w_pass, w_scan;
    logic                            w_to_ds, w_from_ds, w_has_second, w_match;
    logic [wfafc_pkg::ADDR_W-1:0]    w_bssid, w_sta_a, w_sta_b;
    logic [wfafc_pkg::STA_CW-1:0]    w_n_lim, w_idx_inc;
    logic                            w_slot_ok;

    assign i_item.ready         = (r_state == ST_IDLE);
    assign o_result.valid       = r_ovalid;
    assign o_result.counted     = r_ocounted;
    assign o_result.frame_count = r_ocount;

    assign w_n_lim = (int'(i_cfg.station_count) > wfafc_pkg::STATION_ENTRIES)
                   ? wfafc_pkg::STA_CW'(wfafc_pkg::STATION_ENTRIES)
                   : wfafc_pkg::STA_CW'(i_cfg.station_count);
    assign w_idx_inc = wfafc_pkg::STA_CW'(r_idx + 1'b1);
    assign w_slot_ok = (int'(r_eidx) < wfafc_pkg::STATION_ENTRIES);

    assign w_to_ds   = r_fc[wfafc_pkg::FC_TO_DS_BIT];
    assign w_from_ds = r_fc[wfafc_pkg::FC_FROM_DS_BIT];

    always_comb begin
        w_has_second = 1'b0;
        w_sta_b      = r_a2;
        if (w_to_ds) begin
            w_bssid = r_a1;
            w_sta_a = r_a2;
        end else if (w_from_ds) begin
            w_bssid = r_a2;
            w_sta_a = r_a1;
        end else begin
            w_bssid      = r_a3;
            w_sta_a      = r_a1;
            w_has_second = 1'b1;
        end
    end

    assign w_base   = (r_len >= wfafc_pkg::MIN_FRAME_LEN)
                   && ((r_kind == wfafc_pkg::KIND_MGMT) || (r_kind == wfafc_pkg::KIND_DATA));
    assign w_hdr_ok = (r_len >= wfafc_pkg::FULL_HEADER_LEN) && !(w_to_ds && w_from_ds)
                   && (w_bssid == i_cfg.filter_bssid);

    always_comb begin
        case (i_cfg.filter_mode)
            wfafc_pkg::FM_ALL:   w_pass = w_base;
            wfafc_pkg::FM_BSSID: w_pass = w_base && w_hdr_ok;
            default:             w_pass = 1'b0;
        endcase
    end

    assign w_scan  = (i_cfg.filter_mode == wfafc_pkg::FM_STATION) && w_base && w_hdr_ok
                  && (w_n_lim != '0);
    assign w_match = (i_rd_data == w_sta_a) || (w_has_second && (i_rd_data == w_sta_b));

    assign o_wr_addr = wfafc_pkg::STA_AW'(r_eidx);
    assign o_wr_data = r_eaddr;
    assign o_rd_addr = r_idx[wfafc_pkg::STA_AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_len      = r_len;
        n_kind     = r_kind;
        n_fc       = r_fc;
        n_a1       = r_a1;
        n_a2       = r_a2;
        n_a3       = r_a3;
        n_eidx     = r_eidx;
        n_eaddr    = r_eaddr;
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_last     = r_last;
        n_hit      = r_hit;
        n_verdict  = r_verdict;
        n_ovalid   = r_ovalid;
        n_ocounted = r_ocounted;
        n_ocount   = r_ocount;
        n_count    = r_count;
        o_wr_en    = 1'b0;
        o_rd_en    = 1'b0;
        w_load     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_mode  = i_item.mode;
                    n_len   = i_item.frame_length;
                    n_kind  = i_item.frame_kind;
                    n_fc    = i_item.frame_control;
                    n_a1    = i_item.address_one;
                    n_a2    = i_item.address_two;
                    n_a3    = i_item.address_three;
                    n_eidx  = i_item.entry_index;
                    n_eaddr = i_item.entry_address;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_verdict = 1'b0;
                n_state   = ST_DONE;
                case (r_mode)
                    wfafc_pkg::MODE_FRAME: begin
                        if (w_scan) begin
                            n_state = ST_SCAN;
                            n_idx   = '0;
                            n_issue = 1'b1;
                            n_pend  = 1'b0;
                            n_hit   = 1'b0;
                        end else begin
                            n_verdict = w_pass;
                        end
                    end
                    wfafc_pkg::MODE_WRITE: begin
                        o_wr_en = w_slot_ok;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                o_rd_en = r_issue;
                n_pend  = r_issue;
                if (r_issue) begin
                    n_idx  = w_idx_inc;
                    n_last = (w_idx_inc == w_n_lim);
                    if (w_idx_inc == w_n_lim) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_pend) begin
                    n_hit = r_hit || w_match;
                    if (r_last) begin
                        n_verdict = r_hit || w_match;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_result.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load) begin
            if (r_mode == wfafc_pkg::MODE_CLEAR) begin
                n_count = '0;
            end else if (r_verdict) begin
                n_count = r_count + 1'b1;
            end
            n_ovalid   = 1'b1;
            n_ocounted = r_verdict;
            n_ocount   = n_count;
        end else if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issue   <= 1'b0;
            r_pend    <= 1'b0;
            r_last    <= 1'b0;
            r_hit     <= 1'b0;
            r_verdict <= 1'b0;
            r_ovalid  <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_last    <= n_last;
            r_hit     <= n_hit;
            r_verdict <= n_verdict;
            r_ovalid  <= n_ovalid;
            r_count   <= n_count;
            r_idx     <= n_idx;
        end
        r_mode     <= n_mode;
        r_len      <= n_len;
        r_kind     <= n_kind;
        r_fc       <= n_fc;
        r_a1       <= n_a1;
        r_a2       <= n_a2;
        r_a3       <= n_a3;
        r_eidx     <= n_eidx;
        r_eaddr    <= n_eaddr;
        r_ocounted <= n_ocounted;
        r_ocount   <= n_ocount;
    end

`ifndef SYNTHESIS
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == ST_EVAL))
        else $error("accepted item not evaluated");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_idx < w_n_lim))
        else $error("station read beyond active entries");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable(r_count))
        else $error("frame count moved without a result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_verdict && (r_mode == wfafc_pkg::MODE_FRAME))
            |=> (o_result.frame_count == $past(r_count) + 1'b1) && o_result.counted)
        else $error("counted frame did not advance count");
`endif

endmodule

/* hw/rtl/wifi_frame_address_filter_counter_top.sv */
// 802.11 BSSID and station address filter with a wrapping accepted-frame count.
// Input channel i_item carries one item per transfer: a frame header (mode
// frame), a station table write (mode write) or a clear of the count (mode
// clear). Output channel o_result returns exactly one result per item:
// counted and the 32-bit frame count after that item.
// One item is in work at a time. An item passes the evaluate and done states
// to the output register; a frame matched against the station set also takes a
// scan of n = min(station_count, 8) entries that reads one entry per cycle and
// compares the first station address, and the second when neither DS bit is set.
// A new item is taken while a finished result still waits in the output
// register; if the receiver stalls, the following result holds in the block
// and no further item is taken until the output register drains.
// Configuration registers sit on the APB port at byte addresses 0, 8 and 16;
// the user writes them while the block is idle, which the block does not enforce.
// Reset clears the count, the registers and the channel state; the station
// table holds no defined value until written.
module wifi_frame_address_filter_counter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfafc_pkg::PADDR_W-1:0] paddr,
    input  logic [wfafc_pkg::PDATA_W-1:0] pwdata,
    output logic [wfafc_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    wfafc_in_if.sink                      i_item,
    wfafc_out_if.source                   o_result
);

    wfafc_pkg::t_cfg                     w_cfg;
    logic                                w_wr_en;
    logic [wfafc_pkg::STA_AW-1:0]        w_wr_addr;
    logic [wfafc_pkg::ADDR_W-1:0]        w_wr_data;
    logic                                w_rd_en;
    logic [wfafc_pkg::STA_AW-1:0]        w_rd_addr;
    logic [wfafc_pkg::ADDR_W-1:0]        w_rd_data;

    wfafc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wfafc_ram #(
        .DEPTH (wfafc_pkg::STATION_ENTRIES),
        .WIDTH (wfafc_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    wfafc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_item    (i_item),
        .o_result  (o_result),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

endmodule

/* sim/tb_wifi_frame_address_filter_counter_top.sv */
module tb_wifi_frame_address_filter_counter_top;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 75;
    localparam int          LAST_SLOT    = wfafc_pkg::STATION_ENTRIES - 1;
    localparam logic [1:0]  MODE_IGNORED = 2'd3;
    localparam logic [1:0]  FM_UNDEF     = 2'd3;
    localparam logic [1:0]  KIND_CTRL    = 2'd2;
    localparam logic [1:0]  KIND_UNDEF   = 2'd3;
    localparam logic [15:0] FC_NONE      = 16'h0000;
    localparam logic [15:0] FC_TO        = 16'h0100;
    localparam logic [15:0] FC_FROM      = 16'h0200;
    localparam logic [15:0] FC_WDS       = 16'h0300;
    localparam logic [47:0] ADDR_ONES    = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [11:0]                  frame_length;
        logic [1:0]                   frame_kind;
        logic [15:0]                  frame_control;
        logic [wfafc_pkg::ADDR_W-1:0] address_one;
        logic [wfafc_pkg::ADDR_W-1:0] address_two;
        logic [wfafc_pkg::ADDR_W-1:0] address_three;
        logic [2:0]                   entry_index;
        logic [wfafc_pkg::ADDR_W-1:0] entry_address;
    } t_item;

    typedef struct packed {
        logic                          counted;
        logic [wfafc_pkg::COUNT_W-1:0] frame_count;
    } t_tally;

    typedef struct {
        logic            reprogram;
        wfafc_pkg::t_cfg cfg;
        t_item           it;
        logic            known;
        t_tally          want;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [wfafc_pkg::PADDR_W-1:0]   paddr;
    logic [wfafc_pkg::PDATA_W-1:0]   pwdata;
    logic [wfafc_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;

    wfafc_in_if  item_bus();
    wfafc_out_if result_bus();

    wifi_frame_address_filter_counter_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    logic [wfafc_pkg::ADDR_W-1:0]  station_slots [wfafc_pkg::STATION_ENTRIES];
    logic [wfafc_pkg::COUNT_W-1:0] accepted_total;
    wfafc_pkg::t_cfg               filter_cfg;
    t_tally                        awaited_tallies [$];
    t_row                          stimulus_rows [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count = 0;
    int mismatches;
    int items_sent;
    int frames_counted;
    int table_writes;
    int count_clears;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [wfafc_pkg::ADDR_W-1:0] rand48();
        return wfafc_pkg::ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic station_known(logic [wfafc_pkg::ADDR_W-1:0] addr);
        int span;
        span = (filter_cfg.station_count > wfafc_pkg::STATION_ENTRIES) ?
               wfafc_pkg::STATION_ENTRIES : int'(filter_cfg.station_count);
        for (int i = 0; i < span; i++) begin
            if (station_slots[i] == addr) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic frame_passes(t_item it);
        logic                         to_ds;
        logic                         from_ds;
        logic [wfafc_pkg::ADDR_W-1:0] bssid;
        logic [wfafc_pkg::ADDR_W-1:0] sta_a;
        logic [wfafc_pkg::ADDR_W-1:0] sta_b;
        logic                         has_second;
        if (it.frame_length < wfafc_pkg::MIN_FRAME_LEN) begin
            return 1'b0;
        end
        if (it.frame_kind != wfafc_pkg::KIND_MGMT && it.frame_kind != wfafc_pkg::KIND_DATA) begin
            return 1'b0;
        end
        if (filter_cfg.filter_mode == wfafc_pkg::FM_ALL) begin
            return 1'b1;
        end
        if (it.frame_length < wfafc_pkg::FULL_HEADER_LEN) begin
            return 1'b0;
        end
        to_ds   = it.frame_control[wfafc_pkg::FC_TO_DS_BIT];
        from_ds = it.frame_control[wfafc_pkg::FC_FROM_DS_BIT];
        if (to_ds && from_ds) begin
            return 1'b0;
        end
        has_second = 1'b0;
        sta_b      = '0;
        if (to_ds) begin
            bssid = it.address_one;
            sta_a = it.address_two;
        end else if (from_ds) begin
            bssid = it.address_two;
            sta_a = it.address_one;
        end else begin
            bssid      = it.address_three;
            sta_a      = it.address_one;
            sta_b      = it.address_two;
            has_second = 1'b1;
        end
        if (bssid != filter_cfg.filter_bssid) begin
            return 1'b0;
        end
        if (filter_cfg.filter_mode == wfafc_pkg::FM_BSSID) begin
            return 1'b1;
        end
        if (filter_cfg.filter_mode == wfafc_pkg::FM_STATION) begin
            return station_known(sta_a) || (has_second && station_known(sta_b));
        end
        return 1'b0;
    endfunction

    function automatic t_tally predict_tally(t_item it);
        t_tally res;
        res.counted = 1'b0;
        case (it.mode)
            wfafc_pkg::MODE_FRAME: begin
                if (frame_passes(it)) begin
                    accepted_total = accepted_total + 1'b1;
                    res.counted    = 1'b1;
                end
            end
            wfafc_pkg::MODE_WRITE: begin
                if (it.entry_index < wfafc_pkg::STATION_ENTRIES) begin
                    station_slots[it.entry_index] = it.entry_address;
                end
            end
            wfafc_pkg::MODE_CLEAR: begin
                accepted_total = '0;
            end
            default: begin
            end
        endcase
        res.frame_count = accepted_total;
        return res;
    endfunction

    function automatic t_item mk_frame(logic [11:0] len, logic [1:0] kind, logic [15:0] fc,
                                       logic [wfafc_pkg::ADDR_W-1:0] a1,
                                       logic [wfafc_pkg::ADDR_W-1:0] a2,
                                       logic [wfafc_pkg::ADDR_W-1:0] a3);
        t_item it;
        it               = '0;
        it.mode          = wfafc_pkg::MODE_FRAME;
        it.frame_length  = len;
        it.frame_kind    = kind;
        it.frame_control = fc;
        it.address_one   = a1;
        it.address_two   = a2;
        it.address_three = a3;
        return it;
    endfunction

    function automatic t_item mk_ctl(logic [1:0] mode, logic [2:0] idx,
                                     logic [wfafc_pkg::ADDR_W-1:0] addr);
        t_item it;
        it               = '0;
        it.mode          = mode;
        it.entry_index   = idx;
        it.entry_address = addr;
        return it;
    endfunction

    function automatic t_tally tally(logic counted, logic [wfafc_pkg::COUNT_W-1:0] n);
        t_tally res;
        res.counted     = counted;
        res.frame_count = n;
        return res;
    endfunction

    function automatic void add_row(logic reprogram, wfafc_pkg::t_cfg c, t_item it,
                                    logic known, t_tally want);
        t_row row;
        row.reprogram = reprogram;
        row.cfg       = c;
        row.it        = it;
        row.known     = known;
        row.want      = want;
        stimulus_rows.push_back(row);
    endfunction

    function automatic t_item draw_item();
        t_item it;
        int    r;
        it.mode          = wfafc_pkg::MODE_FRAME;
        it.frame_length  = 12'($urandom());
        it.frame_kind    = 2'($urandom());
        it.frame_control = 16'($urandom());
        it.address_one   = rand48();
        it.address_two   = rand48();
        it.address_three = rand48();
        it.entry_index   = 3'($urandom());
        it.entry_address = rand48();
        r = $urandom_range(99);
        if (r < 3) begin
            it.mode = wfafc_pkg::MODE_CLEAR;
        end else if (r < 11) begin
            it.mode = wfafc_pkg::MODE_WRITE;
        end else if (r < 15) begin
            it.mode = MODE_IGNORED;
        end else begin
            r = $urandom_range(99);
            if (r < 10) begin
                it.frame_length = 12'($urandom_range(0, 23));
            end else if (r >= 20) begin
                it.frame_length = 12'($urandom_range(wfafc_pkg::FULL_HEADER_LEN, 4095));
            end
            if ($urandom_range(99) < 85) begin
                it.frame_kind = ($urandom_range(1) != 0) ? wfafc_pkg::KIND_DATA
                                                         : wfafc_pkg::KIND_MGMT;
            end
            r = $urandom_range(9);
            it.frame_control[wfafc_pkg::FC_TO_DS_BIT]   = (r <= 3);
            it.frame_control[wfafc_pkg::FC_FROM_DS_BIT] = (r == 0) || (r >= 4 && r <= 6);
            if ($urandom_range(99) < 75) begin
                if (r >= 1 && r <= 3) begin
                    it.address_one = filter_cfg.filter_bssid;
                end else if (r >= 4 && r <= 6) begin
                    it.address_two = filter_cfg.filter_bssid;
                end else begin
                    it.address_three = filter_cfg.filter_bssid;
                end
            end
            if ($urandom_range(99) < 60) begin
                if (r >= 1 && r <= 3) begin
                    it.address_two = station_slots[$urandom_range(LAST_SLOT)];
                end else begin
                    it.address_one = station_slots[$urandom_range(LAST_SLOT)];
                end
            end
            if (r >= 7 && $urandom_range(99) < 40) begin
                it.address_two = station_slots[$urandom_range(LAST_SLOT)];
            end
        end
        return it;
    endfunction

    task automatic flag(string what, logic [wfafc_pkg::COUNT_W-1:0] want,
                        logic [wfafc_pkg::COUNT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s expected 0x%0h got 0x%0h", what, want, got);
        end
    endtask

    task automatic send_item(t_item it, logic known, t_tally want);
        t_tally pred;
        // hold valid low while idling
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            item_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        item_bus.mode          <= it.mode;
        item_bus.frame_length  <= it.frame_length;
        item_bus.frame_kind    <= it.frame_kind;
        item_bus.frame_control <= it.frame_control;
        item_bus.address_one   <= it.address_one;
        item_bus.address_two   <= it.address_two;
        item_bus.address_three <= it.address_three;
        item_bus.entry_index   <= it.entry_index;
        item_bus.entry_address <= it.entry_address;
        item_bus.valid         <= 1'b1;
        do @(posedge i_clk); while (!item_bus.ready);
        pred = predict_tally(it);
        awaited_tallies.push_back(known ? want : pred);
        items_sent++;
        frames_counted += pred.counted;
        if (it.mode == wfafc_pkg::MODE_WRITE) begin
            table_writes++;
        end
        if (it.mode == wfafc_pkg::MODE_CLEAR) begin
            count_clears++;
        end
    endtask

    task automatic drain_results();
        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_tallies.size() != 0);
    endtask

    task automatic apb_write(logic [wfafc_pkg::REG_IDX_W-1:0] idx,
                             logic [wfafc_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wfafc_pkg::PADDR_W'({idx, {wfafc_pkg::REG_LSB{1'b0}}});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_filter(wfafc_pkg::t_cfg c);
        drain_results();
        apb_write(wfafc_pkg::REG_FILTER_MODE, wfafc_pkg::PDATA_W'(c.filter_mode));
        apb_write(wfafc_pkg::REG_FILTER_BSSID, wfafc_pkg::PDATA_W'(c.filter_bssid));
        apb_write(wfafc_pkg::REG_STATION_COUNT, wfafc_pkg::PDATA_W'(c.station_count));
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        filter_cfg   = c;
    endtask

    always @(posedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_tally want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (awaited_tallies.size() == 0) begin
                flag("unexpected transfer, frame_count", '0, result_bus.frame_count);
            end else begin
                want = awaited_tallies.pop_front();
                if (result_bus.counted !== want.counted) begin
                    flag("counted", wfafc_pkg::COUNT_W'(want.counted),
                         wfafc_pkg::COUNT_W'(result_bus.counted));
                end
                if (result_bus.frame_count !== want.frame_count) begin
                    flag("frame_count", want.frame_count, result_bus.frame_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        wfafc_pkg::t_cfg c;
        t_item           it;

        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        item_bus.valid         <= 1'b0;
        item_bus.mode          <= wfafc_pkg::MODE_FRAME;
        item_bus.frame_length  <= '0;
        item_bus.frame_kind    <= wfafc_pkg::KIND_MGMT;
        item_bus.frame_control <= FC_NONE;
        item_bus.address_one   <= '0;
        item_bus.address_two   <= '0;
        item_bus.address_three <= '0;
        item_bus.entry_index   <= '0;
        item_bus.entry_address <= '0;
        mismatches             = 0;
        items_sent             = 0;
        frames_counted         = 0;
        table_writes           = 0;
        count_clears           = 0;
        sender_idle_pct        = 0;
        receiver_stall_pct     = 0;
        accepted_total         = '0;
        filter_cfg             = '0;
        foreach (station_slots[i]) begin
            station_slots[i] = '0;
        end

        add_row(1'b0, '0, mk_ctl(wfafc_pkg::MODE_CLEAR, 3'd0, '0), 1'b1, tally(1'b0, 32'd0));
        add_row(1'b0, '0, mk_frame(12'd9, wfafc_pkg::KIND_MGMT, FC_NONE, '0, '0, '0),
                1'b1, tally(1'b0, 32'd0));
        add_row(1'b0, '0, mk_frame(12'd10, wfafc_pkg::KIND_MGMT, FC_NONE, '0, '0, '0),
                1'b1, tally(1'b1, 32'd1));
        add_row(1'b0, '0, mk_frame(12'd4095, wfafc_pkg::KIND_DATA, 16'hFFFF, ADDR_ONES,
                                   ADDR_ONES, ADDR_ONES), 1'b1, tally(1'b1, 32'd2));
        add_row(1'b0, '0, mk_frame(12'd100, KIND_CTRL, FC_NONE, '0, '0, '0),
                1'b1, tally(1'b0, 32'd2));
        add_row(1'b0, '0, mk_frame(12'd100, KIND_UNDEF, FC_NONE, '0, '0, '0),
                1'b1, tally(1'b0, 32'd2));
        it               = mk_frame(12'd4095, KIND_UNDEF, 16'hFFFF, ADDR_ONES, ADDR_ONES,
                                    ADDR_ONES);
        it.mode          = MODE_IGNORED;
        it.entry_index   = 3'd7;
        it.entry_address = ADDR_ONES;
        add_row(1'b0, '0, it, 1'b1, tally(1'b0, 32'd2));
        for (int i = 0; i < wfafc_pkg::STATION_ENTRIES; i++) begin
            add_row(1'b0, '0, mk_ctl(wfafc_pkg::MODE_WRITE, 3'(i),
                                     (i == 0) ? ADDR_ONES :
                                     (i == LAST_SLOT) ? 48'h0 :
                                     48'h0A1B_2C3D_4E00 + wfafc_pkg::ADDR_W'(i)),
                    1'b1, tally(1'b0, 32'd2));
        end
        add_row(1'b1, {wfafc_pkg::FM_BSSID, ADDR_ONES, 4'd0},
                mk_frame(12'd23, wfafc_pkg::KIND_DATA, FC_NONE, '0, '0, ADDR_ONES),
                1'b1, tally(1'b0, 32'd2));
        add_row(1'b0, '0, mk_frame(12'd24, wfafc_pkg::KIND_MGMT, FC_TO, ADDR_ONES, '0, '0),
                1'b1, tally(1'b1, 32'd3));
        add_row(1'b0, '0, mk_frame(12'd24, wfafc_pkg::KIND_DATA, FC_FROM, '0, ADDR_ONES, '0),
                1'b0, '0);
        add_row(1'b0, '0, mk_frame(12'd24, wfafc_pkg::KIND_DATA, FC_WDS, ADDR_ONES, ADDR_ONES,
                                   ADDR_ONES), 1'b0, '0);
        add_row(1'b0, '0, mk_frame(12'd24, wfafc_pkg::KIND_MGMT, FC_NONE, ADDR_ONES, ADDR_ONES,
                                   48'h1), 1'b0, '0);
        add_row(1'b1, {wfafc_pkg::FM_STATION, 48'h0, 4'd15},
                mk_frame(12'd24, wfafc_pkg::KIND_DATA, FC_NONE, 48'h5555_5555_5555, 48'h0,
                         48'h0), 1'b0, '0);
        add_row(1'b0, '0, mk_frame(12'd100, wfafc_pkg::KIND_MGMT, FC_TO, 48'h0, ADDR_ONES,
                                   48'h5), 1'b0, '0);
        add_row(1'b0, '0, mk_frame(12'd100, wfafc_pkg::KIND_DATA, FC_FROM, 48'h123, 48'h0,
                                   48'h0), 1'b0, '0);
        add_row(1'b1, {FM_UNDEF, 48'h0, 4'd8},
                mk_frame(12'd4095, wfafc_pkg::KIND_MGMT, FC_NONE, ADDR_ONES, 48'h0, 48'h0),
                1'b0, '0);
        add_row(1'b0, '0, mk_ctl(wfafc_pkg::MODE_CLEAR, 3'd0, '0), 1'b1, tally(1'b0, 32'd0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stimulus_rows[k]) begin
            if (stimulus_rows[k].reprogram) begin
                program_filter(stimulus_rows[k].cfg);
            end
            send_item(stimulus_rows[k].it, stimulus_rows[k].known, stimulus_rows[k].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: c = {wfafc_pkg::FM_ALL, rand48(), 4'd0};
                1: c = {wfafc_pkg::FM_BSSID, ADDR_ONES, 4'd8};
                2: c = {wfafc_pkg::FM_STATION, rand48(), 4'd8};
                3: c = {wfafc_pkg::FM_STATION, 48'h0, 4'($urandom_range(1, 7))};
                4: c = {wfafc_pkg::FM_STATION, rand48(), 4'd15};
                5: c = {FM_UNDEF, rand48(), 4'd3};
                6: c = {wfafc_pkg::FM_BSSID, rand48(), 4'd0};
                default: c = {wfafc_pkg::FM_STATION, rand48(), 4'd0};
            endcase
            program_filter(c);
            case (p % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 87;
                end
                default: begin
                    sender_idle_pct    = 16;
                    receiver_stall_pct = 16;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_item(draw_item(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (awaited_tallies.size() != 0) begin
            flag("results never returned", '0, wfafc_pkg::COUNT_W'(awaited_tallies.size()));
        end
        $display("covered %0d items over %0d filter settings: %0d frames counted,",
                 items_sent, PHASES + 4, frames_counted);
        $display("%0d table writes, %0d clears, result mismatches: %0d",
                 table_writes, count_clears, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
